// ===== rtl/core/json_string_escaper_macros.svh =====
// assertion macros used by the escaper rtl
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define JSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define JSE_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define JSE_ASSERT(name, prop, msg)
`define JSE_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ===== rtl/core/jse_pkg.sv =====
package jse_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  localparam int unsigned SEQ_MAX   = 6;
  localparam int unsigned SEQ_CNT_W = $clog2(SEQ_MAX + 1);

  // characters used by the escapes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // raw control bytes with short escapes, plus DEL and space that bound the rest
  localparam logic [7:0] RAW_BS  = 8'h08;
  localparam logic [7:0] RAW_TAB = 8'h09;
  localparam logic [7:0] RAW_LF  = 8'h0A;
  localparam logic [7:0] RAW_FF  = 8'h0C;
  localparam logic [7:0] RAW_CR  = 8'h0D;
  localparam logic [7:0] RAW_DEL = 8'h7F;
  localparam logic [7:0] RAW_SP  = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_t;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [SEQ_CNT_W-1:0]    count;
    logic                    done;
  } seq_t;

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + ext;
    end else begin
      return 8'h57 + ext;
    end
  endfunction

endpackage

// ===== rtl/core/json_string_escaper.sv =====
// an accepted item is held in the input register s1_q, then moves into the output byte shifter
// once that is free; throughput: one output byte per cycle while out_stall_i is low; a plain
// byte, start or end gives one output byte, a two-character escape two bytes and a \u00xx
// escape six bytes, drained by the output byte shifter; unused commands give no output bytes
// reset: clears the input and output valid state only, no clearing pass
`include "json_string_escaper_macros.svh"

module json_string_escaper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jse_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output jse_pkg::out_t out_o
);

  logic                              s1_valid_q, s1_valid_d;
  jse_pkg::in_t                      s1_q;
  logic [jse_pkg::SEQ_MAX-1:0][7:0]  seq_q, seq_d;
  logic [jse_pkg::SEQ_CNT_W-1:0]     cnt_q, cnt_d;
  logic                              done_q, done_d;
  jse_pkg::seq_t                     dec;
  logic                              in_accept, out_pop, exp_free, s1_move;

  jse_decode u_decode (
    .item_i (s1_q),
    .seq_o  (dec)
  );

  assign out_valid_o = (cnt_q != '0);
  assign out_pop     = out_valid_o && !out_stall_i;
  // shifter is free when empty or its last byte leaves this cycle
  assign exp_free    = (cnt_q == '0) ||
                       (cnt_q == jse_pkg::SEQ_CNT_W'(1) && !out_stall_i);
  assign s1_move     = s1_valid_q && exp_free;
  assign in_stall_o  = s1_valid_q && !exp_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign out_o.out_byte    = seq_q[0];
  assign out_o.run_last    = (cnt_q == jse_pkg::SEQ_CNT_W'(1));
  assign out_o.string_done = done_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    seq_d  = seq_q;
    done_d = done_q;
    if (s1_move) begin
      cnt_d  = dec.count;
      seq_d  = dec.bytes;
      done_d = dec.done;
    end else if (out_pop) begin
      cnt_d = cnt_q - jse_pkg::SEQ_CNT_W'(1);
      seq_d = {8'h00, seq_q[jse_pkg::SEQ_MAX-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_i;
    end
    seq_q  <= seq_d;
    done_q <= done_d;
  end

  `JSE_ASSERT_NEVER(a_cnt_range, cnt_q > jse_pkg::SEQ_CNT_W'(jse_pkg::SEQ_MAX), "byte count out of range")

  `JSE_ASSERT(a_done_is_quote, out_valid_o && out_o.string_done |-> out_o.run_last && out_o.out_byte == jse_pkg::CH_QUOTE, "string end not on a closing quote")

  `JSE_ASSERT(a_no_gap, out_pop && !out_o.run_last |=> out_valid_o, "gap inside an escape sequence")

  `JSE_ASSERT(a_move_gives_output, s1_move && (s1_q.cmd == jse_pkg::CMD_START || s1_q.cmd == jse_pkg::CMD_DATA || s1_q.cmd == jse_pkg::CMD_END) |=> out_valid_o, "item lost on its way to the output")

  `JSE_ASSERT(a_stall_blocks_input, in_stall_o |-> s1_valid_q && out_valid_o, "input stalled with nothing pending")

endmodule

// ===== rtl/core/jse_decode.sv =====
module jse_decode (
  input  jse_pkg::in_t  item_i,
  output jse_pkg::seq_t seq_o
);

  always_comb begin
    seq_o = '0;
    case (item_i.cmd)
      jse_pkg::CMD_START: begin
        seq_o.bytes[0] = jse_pkg::CH_QUOTE;
        seq_o.count    = jse_pkg::SEQ_CNT_W'(1);
      end
      jse_pkg::CMD_END: begin
        seq_o.bytes[0] = jse_pkg::CH_QUOTE;
        seq_o.count    = jse_pkg::SEQ_CNT_W'(1);
        seq_o.done     = 1'b1;
      end
      jse_pkg::CMD_DATA: begin
        seq_o.bytes[0] = jse_pkg::CH_BSLASH;
        seq_o.count    = jse_pkg::SEQ_CNT_W'(2);
        case (item_i.in_byte)
          jse_pkg::CH_QUOTE:  seq_o.bytes[1] = jse_pkg::CH_QUOTE;
          jse_pkg::CH_BSLASH: seq_o.bytes[1] = jse_pkg::CH_BSLASH;
          jse_pkg::CH_SLASH:  seq_o.bytes[1] = jse_pkg::CH_SLASH;
          jse_pkg::RAW_BS:    seq_o.bytes[1] = jse_pkg::CH_B;
          jse_pkg::RAW_FF:    seq_o.bytes[1] = jse_pkg::CH_F;
          jse_pkg::RAW_LF:    seq_o.bytes[1] = jse_pkg::CH_N;
          jse_pkg::RAW_CR:    seq_o.bytes[1] = jse_pkg::CH_R;
          jse_pkg::RAW_TAB:   seq_o.bytes[1] = jse_pkg::CH_T;
          default: begin
            if (item_i.in_byte < jse_pkg::RAW_SP || item_i.in_byte == jse_pkg::RAW_DEL) begin
              // remaining control bytes as \u00xx
              seq_o.bytes[1] = jse_pkg::CH_U;
              seq_o.bytes[2] = jse_pkg::CH_ZERO;
              seq_o.bytes[3] = jse_pkg::CH_ZERO;
              seq_o.bytes[4] = jse_pkg::hex_lower(item_i.in_byte[7:4]);
              seq_o.bytes[5] = jse_pkg::hex_lower(item_i.in_byte[3:0]);
              seq_o.count    = jse_pkg::SEQ_CNT_W'(6);
            end else begin
              seq_o.bytes[0] = item_i.in_byte;
              seq_o.count    = jse_pkg::SEQ_CNT_W'(1);
            end
          end
        endcase
      end
      default: begin
        // unused command gives no output
        seq_o = '0;
      end
    endcase
  end

endmodule
